### rtl/scel_pkg.sv
`default_nettype none

package scel_pkg;

  // table and logit geometry
  localparam int TABLE_ENTRIES = 1024;
  localparam int LOGIT_BITS    = 16;
  localparam int FRAC_BITS     = LOGIT_BITS - 4;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int AX_W          = LOGIT_BITS;
  localparam int IDXP_W        = AX_W + IDX_W;
  localparam int LABEL_W       = 8;

  // stream payload widths
  localparam int S_DATA_W = ((LOGIT_BITS + LABEL_W + 7) / 8) * 8;
  localparam int GRAD_W   = 18;
  localparam int MEAN_W   = 32;
  localparam int M_DATA_W = ((GRAD_W + MEAN_W + 7) / 8) * 8;

  // configuration registers
  localparam int LS_W      = 25;
  localparam int GS_W      = 24;
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_SCALE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRAD_SCALE = CFG_IDX_W'(1);
  localparam logic [LS_W-1:0] LS_RESET = LS_W'(24'hFFFFFF) + LS_W'(1);
  localparam logic [GS_W-1:0] GS_RESET = GS_W'(65536);

  // datapath widths
  localparam int SIG_W  = 17;
  localparam int SP_W   = 16;
  localparam int AXS_W  = AX_W + 16 - FRAC_BITS;
  localparam int TERM_W = AXS_W + 1;
  localparam int SUM_W  = 48;
  localparam int HALF_W = 24;
  localparam int PROD_W = SIG_W + GS_W;
  localparam int RND_W  = PROD_W - 16;
  localparam int MP_W   = HALF_W + LS_W;
  localparam logic [SIG_W-1:0] ONE_Q16 = SIG_W'(65536);

  // table step 8/TABLE_ENTRIES in q32
  localparam logic [63:0] STEP_H = (64'd8 << 32) / 64'(TABLE_ENTRIES);

  // request queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [AX_W-1:0]  ax;
    logic [IDX_W-1:0] idx;
    logic             neg;
    logic             valid;
    logic             one;
    logic             last;
  } elem_t;

  typedef struct packed {
    logic [FIFO_CW-1:0] count;
    logic               empty;
    logic               full;
  } fifo_stat_t;

  typedef logic [SIG_W-1:0] sig_rom_t [TABLE_ENTRIES];
  typedef logic [SP_W-1:0]  sp_rom_t  [TABLE_ENTRIES];

  // unsigned 64-bit quotient, restoring shift and subtract
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^-(8/TABLE_ENTRIES) in q32, taylor series
  function automatic logic [63:0] step_ratio();
    logic [63:0] pos;
    logic [63:0] nsum;
    logic [63:0] term;
    logic [63:0] kk;
    pos  = 64'd1 << 32;
    nsum = 64'd0;
    term = 64'd1 << 32;
    for (int k = 1; k <= 12; k++) begin
      kk   = 64'(k);
      term = udiv64((term * STEP_H) >> 32, kk);
      if (kk[0]) begin
        nsum = nsum + term;
      end else begin
        pos = pos + term;
      end
    end
    return pos - nsum;
  endfunction

  // sigmoid of |x| in q16
  function automatic sig_rom_t build_sig_rom();
    sig_rom_t    rom;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] den;
    r = step_ratio();
    e = 64'd1 << 32;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      den    = (64'd1 << 32) + e;
      rom[i] = SIG_W'(udiv64((64'd1 << 48) + (den >> 1), den));
      e      = (e * r + (64'd1 << 31)) >> 32;
    end
    return rom;
  endfunction

  // softplus(-|x|) in q16, ln(1+e) as 2*atanh(e/(2+e)) in q30
  function automatic sp_rom_t build_sp_rom();
    sp_rom_t     rom;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] dv;
    r = step_ratio();
    e = 64'd1 << 32;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      z    = udiv64(e << 30, (64'd1 << 33) + e);
      z2   = (z * z) >> 30;
      term = z;
      acc  = 64'd0;
      for (int k = 0; k < 24; k++) begin
        dv   = 64'(2 * k + 1);
        acc  = acc + udiv64(term, dv);
        term = (term * z2) >> 30;
      end
      rom[i] = SP_W'((64'd2 * acc + (64'd1 << 13)) >> 14);
      e      = (e * r + (64'd1 << 31)) >> 32;
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

### rtl/scel_front.sv
`default_nettype none

module scel_front (
  input  logic signed [scel_pkg::LOGIT_BITS-1:0] logit,
  input  logic [scel_pkg::LABEL_W-1:0]           label,
  input  logic                                   batch_end,
  output scel_pkg::elem_t                        elem
);

  logic [scel_pkg::AX_W-1:0]   lu;
  logic [scel_pkg::AX_W-1:0]   ax;
  logic                        neg;
  logic [scel_pkg::IDXP_W-1:0] scaled;
  logic [scel_pkg::IDXP_W-1:0] shifted;
  logic [scel_pkg::IDX_W-1:0]  idx;

  assign lu  = $unsigned(logit);
  assign neg = lu[scel_pkg::AX_W-1];
  // most negative logit wraps to 2^(n-1), which fits unsigned
  assign ax  = neg ? (~lu + scel_pkg::AX_W'(1)) : lu;

  assign scaled  = scel_pkg::IDXP_W'(ax) * scel_pkg::IDXP_W'(scel_pkg::TABLE_ENTRIES);
  assign shifted = scaled >> (scel_pkg::LOGIT_BITS - 1);
  assign idx = (shifted > scel_pkg::IDXP_W'(scel_pkg::TABLE_ENTRIES - 1)) ?
               scel_pkg::IDX_W'(scel_pkg::TABLE_ENTRIES - 1) : shifted[scel_pkg::IDX_W-1:0];

  always_comb begin
    elem       = '0;
    elem.ax    = ax;
    elem.idx   = idx;
    elem.neg   = neg;
    elem.valid = (label == scel_pkg::LABEL_W'(0)) || (label == scel_pkg::LABEL_W'(1));
    elem.one   = (label == scel_pkg::LABEL_W'(1));
    elem.last  = batch_end;
  end

endmodule

`default_nettype wire

### rtl/scel_fifo.sv
`default_nettype none

module scel_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  scel_pkg::elem_t        din,
  input  logic                   pop,
  output scel_pkg::elem_t        dout,
  output scel_pkg::fifo_stat_t   stat
);

  scel_pkg::elem_t                 mem [scel_pkg::FIFO_DEPTH];
  logic [scel_pkg::FIFO_AW-1:0]    wr_ptr;
  logic [scel_pkg::FIFO_AW-1:0]    rd_ptr;
  logic [scel_pkg::FIFO_CW-1:0]    count;
  logic                            do_push;
  logic                            do_pop;

  assign do_push = push && (count != scel_pkg::FIFO_CW'(scel_pkg::FIFO_DEPTH));
  assign do_pop  = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == scel_pkg::FIFO_AW'(scel_pkg::FIFO_DEPTH - 1)) ?
                  '0 : wr_ptr + scel_pkg::FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == scel_pkg::FIFO_AW'(scel_pkg::FIFO_DEPTH - 1)) ?
                  '0 : rd_ptr + scel_pkg::FIFO_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + scel_pkg::FIFO_CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - scel_pkg::FIFO_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  assign dout       = mem[rd_ptr];
  assign stat.count = count;
  assign stat.empty = (count == '0);
  assign stat.full  = (count == scel_pkg::FIFO_CW'(scel_pkg::FIFO_DEPTH));

endmodule

`default_nettype wire

### rtl/scel_back.sv
`default_nettype none

module scel_back (
  input  logic                               clk,
  input  logic                               rst,
  input  scel_pkg::elem_t                    elem,
  input  logic                               avail,
  output logic                               pop,
  input  logic [scel_pkg::LS_W-1:0]          loss_scale,
  input  logic [scel_pkg::GS_W-1:0]          grad_scale,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [scel_pkg::GRAD_W-1:0] gradient,
  output logic [scel_pkg::MEAN_W-1:0]        mean_loss,
  output logic                               loss_valid
);

  typedef struct packed {
    logic valid;
    logic one;
    logic last;
  } flags_t;

  localparam scel_pkg::sig_rom_t SIG_ROM = scel_pkg::build_sig_rom();
  localparam scel_pkg::sp_rom_t  SP_ROM  = scel_pkg::build_sp_rom();

  localparam logic [scel_pkg::RND_W-1:0] POS_LIMIT = scel_pkg::RND_W'(2 ** (scel_pkg::GRAD_W - 1) - 1);
  localparam logic [scel_pkg::RND_W-1:0] NEG_LIMIT = scel_pkg::RND_W'(2 ** (scel_pkg::GRAD_W - 1));
  localparam logic [scel_pkg::GRAD_W-1:0] GRAD_MAX = {1'b0, {(scel_pkg::GRAD_W - 1){1'b1}}};
  localparam logic [scel_pkg::GRAD_W-1:0] GRAD_MIN = {1'b1, {(scel_pkg::GRAD_W - 1){1'b0}}};
  localparam logic [scel_pkg::PROD_W-1:0] RND_HALF = scel_pkg::PROD_W'(32768);

  logic adv;

  // s1: rom read
  logic                          s1_valid;
  flags_t                        s1_flags;
  logic [scel_pkg::AX_W-1:0]     s1_ax;
  logic                          s1_neg;
  logic [scel_pkg::SIG_W-1:0]    sig_q;
  logic [scel_pkg::SP_W-1:0]     sp_q;

  // s2: magnitude and loss term
  logic                          s2_valid;
  flags_t                        s2_flags;
  logic [scel_pkg::SIG_W-1:0]    s2_mag;
  logic [scel_pkg::TERM_W-1:0]   s2_term;

  // s3: product and batch sum
  logic                          s3_valid;
  flags_t                        s3_flags;
  logic [scel_pkg::PROD_W-1:0]   s3_prod;
  logic [scel_pkg::SUM_W-1:0]    s3_sum;
  logic [scel_pkg::SUM_W-1:0]    loss_sum;

  // s4: rounding and mean partial products
  logic                          s4_valid;
  flags_t                        s4_flags;
  logic [scel_pkg::RND_W-1:0]    s4_rnd;
  logic [scel_pkg::MP_W-1:0]     s4_mhi;
  logic [scel_pkg::MP_W-1:0]     s4_mlo;

  logic [scel_pkg::SIG_W-1:0]        sigx;
  logic [scel_pkg::SIG_W-1:0]        mag;
  logic [scel_pkg::AX_W+15:0]        ax_wide;
  logic [scel_pkg::AXS_W-1:0]        axs;
  logic [scel_pkg::TERM_W-1:0]       term;
  logic [scel_pkg::SUM_W:0]          sum_add;
  logic [scel_pkg::SUM_W-1:0]        sum_used;
  logic [scel_pkg::PROD_W-1:0]       prod_rnd;
  logic [scel_pkg::MP_W:0]           mean_sum;
  logic [scel_pkg::MEAN_W-1:0]       mean_sat;
  logic [scel_pkg::GRAD_W-1:0]       grad_next;

  assign adv = !out_valid || out_ready;
  assign pop = adv && avail;

  always_comb begin
    sigx    = s1_neg ? (scel_pkg::ONE_Q16 - sig_q) : sig_q;
    mag     = s1_flags.one ? (scel_pkg::ONE_Q16 - sigx) : sigx;
    ax_wide = {s1_ax, 16'b0};
    axs     = scel_pkg::AXS_W'(ax_wide >> scel_pkg::FRAC_BITS);
    term    = scel_pkg::TERM_W'(sp_q) +
              ((s1_flags.one == s1_neg) ? scel_pkg::TERM_W'(axs) : '0);
  end

  // saturating batch accumulator
  always_comb begin
    sum_add  = {1'b0, loss_sum} + (scel_pkg::SUM_W + 1)'(s2_term);
    sum_used = loss_sum;
    if (s2_flags.valid) begin
      sum_used = sum_add[scel_pkg::SUM_W] ? '1 : sum_add[scel_pkg::SUM_W-1:0];
    end
  end

  assign prod_rnd = s3_prod + RND_HALF;

  always_comb begin
    mean_sum = (scel_pkg::MP_W + 1)'(s4_mhi) +
               (scel_pkg::MP_W + 1)'(s4_mlo >> scel_pkg::HALF_W);
    mean_sat = (mean_sum > (scel_pkg::MP_W + 1)'({scel_pkg::MEAN_W{1'b1}})) ?
               '1 : mean_sum[scel_pkg::MEAN_W-1:0];
    grad_next = '0;
    if (s4_flags.valid) begin
      if (s4_flags.one) begin
        grad_next = (s4_rnd > NEG_LIMIT) ? GRAD_MIN :
                    (scel_pkg::GRAD_W'(0) - s4_rnd[scel_pkg::GRAD_W-1:0]);
      end else begin
        grad_next = (s4_rnd > POS_LIMIT) ? GRAD_MAX : s4_rnd[scel_pkg::GRAD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
      loss_sum  <= '0;
    end else if (adv) begin
      s1_valid  <= pop;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
      if (s2_valid) begin
        loss_sum <= s2_flags.last ? '0 : sum_used;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_flags <= '{valid: elem.valid, one: elem.one, last: elem.last};
      s1_ax    <= elem.ax;
      s1_neg   <= elem.neg;
      sig_q    <= SIG_ROM[elem.idx];
      sp_q     <= SP_ROM[elem.idx];

      s2_flags <= s1_flags;
      s2_mag   <= mag;
      s2_term  <= term;

      s3_flags <= s2_flags;
      s3_prod  <= scel_pkg::PROD_W'(s2_mag) * scel_pkg::PROD_W'(grad_scale);
      s3_sum   <= sum_used;

      s4_flags <= s3_flags;
      s4_rnd   <= prod_rnd[scel_pkg::PROD_W-1:16];
      s4_mhi   <= scel_pkg::MP_W'(s3_sum[scel_pkg::SUM_W-1:scel_pkg::HALF_W]) *
                  scel_pkg::MP_W'(loss_scale);
      s4_mlo   <= scel_pkg::MP_W'(s3_sum[scel_pkg::HALF_W-1:0]) *
                  scel_pkg::MP_W'(loss_scale);

      gradient   <= $signed(grad_next);
      mean_loss  <= s4_flags.last ? mean_sat : '0;
      loss_valid <= s4_flags.last;
    end
  end

endmodule

`default_nettype wire

### rtl/sigmoid_cross_entropy_loss_grad_core.sv
// path: an accepted request passes the request queue, stages s1 to s4 and the output register
// throughput: one request per cycle unless m_tready stalls the result side, set by the loss accumulator
// and the one-read-per-cycle softplus and sigmoid roms
// reset: synchronous; clears the request queue, pipeline valids and batch sum,
// loads loss_scale = 2^24 and grad_scale = 1.0; roms are constant, no fill pass
`default_nettype none

module sigmoid_cross_entropy_loss_grad_core (
  input  logic                            clk,
  input  logic                            rst,
  // request side
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [scel_pkg::S_DATA_W-1:0]   s_tdata,   // logit, label
  input  logic                            s_tlast,   // batch_end
  // result side
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [scel_pkg::M_DATA_W-1:0]   m_tdata,   // gradient, mean_loss, zero pad
  output logic                            m_tlast,   // loss_valid
  // configuration writes
  input  logic                            cfg_we,
  input  logic [scel_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scel_pkg::CFG_W-1:0]      cfg_data
);

  logic [scel_pkg::LS_W-1:0]           loss_scale;
  logic [scel_pkg::GS_W-1:0]           grad_scale;

  logic signed [scel_pkg::LOGIT_BITS-1:0] logit;
  logic [scel_pkg::LABEL_W-1:0]        label;
  scel_pkg::elem_t                     front_elem;
  scel_pkg::elem_t                     queue_elem;
  scel_pkg::fifo_stat_t                fifo_stat;
  logic                                fifo_push;
  logic                                fifo_pop;

  logic signed [scel_pkg::GRAD_W-1:0]  gradient;
  logic [scel_pkg::MEAN_W-1:0]         mean_loss;
  logic                                loss_valid;

  // config registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      loss_scale <= scel_pkg::LS_RESET;
      grad_scale <= scel_pkg::GS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        scel_pkg::REG_LOSS_SCALE: begin
          loss_scale <= cfg_data[scel_pkg::LS_W-1:0];
        end
        scel_pkg::REG_GRAD_SCALE: begin
          grad_scale <= cfg_data[scel_pkg::GS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // unpack request fields
  assign logit = $signed(s_tdata[scel_pkg::LOGIT_BITS-1:0]);
  assign label = s_tdata[scel_pkg::LOGIT_BITS +: scel_pkg::LABEL_W];

  // front: absolute value, table index and label class
  scel_front u_front (
    .logit     (logit),
    .label     (label),
    .batch_end (s_tlast),
    .elem      (front_elem)
  );

  // ready depends only on queue occupancy, so no path from m_tready
  assign s_tready  = !fifo_stat.full;
  assign fifo_push = s_tvalid && s_tready;

  // short queue decouples the front from the back pipeline
  scel_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (fifo_push),
    .din  (front_elem),
    .pop  (fifo_pop),
    .dout (queue_elem),
    .stat (fifo_stat)
  );

  // back: rom lookup, accumulate, scale, round and saturate
  scel_back u_back (
    .clk        (clk),
    .rst        (rst),
    .elem       (queue_elem),
    .avail      (!fifo_stat.empty),
    .pop        (fifo_pop),
    .loss_scale (loss_scale),
    .grad_scale (grad_scale),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .gradient   (gradient),
    .mean_loss  (mean_loss),
    .loss_valid (loss_valid)
  );

  // pack result fields, gradient in the low bits
  assign m_tdata = scel_pkg::M_DATA_W'({mean_loss, $unsigned(gradient)});
  assign m_tlast = loss_valid;

`ifndef SYNTHESIS
  // mean is only reported on the batch-end result
  a_mean_only_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[scel_pkg::GRAD_W +: scel_pkg::MEAN_W] == '0))
    else $error("mean_loss nonzero on a non-final result");

  // back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    fifo_pop |-> !fifo_stat.empty)
    else $error("queue popped while empty");

  // a lone push grows the queue by exactly one
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (fifo_push && !fifo_pop) |=> (fifo_stat.count == $past(fifo_stat.count) + 1'b1))
    else $error("queue count did not follow a push");
`endif

endmodule

`default_nettype wire
